// File: hdl/chma_pkg.sv
// shared constants, register codes and control structs of the channel moving average
package chma_pkg;

  localparam int WINDOW_MAX_DEF = 64;

  localparam int CODE_W   = 12;
  localparam int CHAN_W   = 8;
  localparam int WIN_W    = 7;
  localparam int FRAC_W   = 8;
  localparam int MEAN_W   = CODE_W + FRAC_W;
  localparam int IDX_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam int IN_TDATA_W  = ((CODE_W + 7) / 8) * 8;
  localparam int IN_TUSER_W  = CHAN_W;
  localparam int OUT_TDATA_W = ((MEAN_W + IDX_W + 7) / 8) * 8;

  localparam int DIV_CNT_W = $clog2(MEAN_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_SELECT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 1'd1;

  localparam logic [CHAN_W-1:0] CHAN_SEL_RST = 8'd0;
  localparam logic [WIN_W-1:0]  WIN_LEN_RST  = 7'd4;

  typedef struct packed {
    logic load;
    logic rd_step;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic rd_empty;
    logic acc_pend;
    logic div_last;
  } stat_t;

endpackage

// File: hdl/chma_ctrl.sv
// sequencer: accept, sum the window, divide, hand the result to the output register
module chma_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  chma_pkg::stat_t st,
  output chma_pkg::cmd_t  cmd
);
  import chma_pkg::*;

  localparam logic [1:0] IDLE = 2'd0;
  localparam logic [1:0] SUM  = 2'd1;
  localparam logic [1:0] DIV  = 2'd2;
  localparam logic [1:0] OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic       accept;

  assign in_tready  = (state_r == IDLE);
  assign out_tvalid = out_vld_r;
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.load  = accept;
    unique case (state_r)
      IDLE: begin
        if (accept && st.match) state_nxt = SUM;
      end
      SUM: begin
        if (st.rd_empty && !st.acc_pend) begin
          cmd.div_start = 1'b1;
          state_nxt     = DIV;
        end else begin
          cmd.rd_step = !st.rd_empty;
        end
      end
      DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = OUT;
      end
      OUT: begin
        // wait for the output register to free up
        if (!out_vld_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_vld_r && out_tready) out_vld_nxt = 1'b0;
    if (cmd.out_load) out_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

// File: hdl/chma_dp.sv
// datapath: config registers, history ring, window sum and restoring divider
module chma_dp #(
  parameter int WINDOW_MAX = chma_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [chma_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [chma_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [chma_pkg::CODE_W-1:0]       in_code,
  input  logic [chma_pkg::CHAN_W-1:0]       in_chan,
  input  logic                              in_last,
  input  chma_pkg::cmd_t                    cmd,
  output chma_pkg::stat_t                   st,
  output logic [chma_pkg::MEAN_W-1:0]       mean_q8,
  output logic [chma_pkg::IDX_W-1:0]        sample_index
);
  import chma_pkg::*;

  localparam int PTR_W = $clog2(WINDOW_MAX);
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = CODE_W + CNT_W;

  // config
  logic [CHAN_W-1:0] chan_sel_r;
  logic [WIN_W-1:0]  win_len_r;

  // history state
  logic [CODE_W-1:0] ring [WINDOW_MAX];
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [IDX_W-1:0]  seen_r;

  // per-item work
  logic [CNT_W-1:0]  win_c, n_nxt, n_r;
  logic [PTR_W-1:0]  rd_ptr_r, rd_addr;
  logic [CNT_W-1:0]  rd_left_r;
  logic              rd_vld_r;
  logic [CODE_W-1:0] rd_data_r;
  logic [SUM_W-1:0]  sum_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CNT_W-1:0]  rem_r;
  logic [MEAN_W-1:0] quo_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [CNT_W:0]    shifted, diff;
  logic              ge;
  logic [MEAN_W-1:0] mean_r;
  logic [IDX_W-1:0]  oidx_r;
  logic              sel_load;

  assign sel_load = cmd.load && st.match;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_sel_r <= CHAN_SEL_RST;
      win_len_r  <= WIN_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNEL_SELECT: chan_sel_r <= cfg_wdata[CHAN_W-1:0];
        CFG_WINDOW_LENGTH:  win_len_r  <= cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize saturates to the ring depth
  always_comb begin
    if (win_len_r == '0)                     win_c = CNT_W'(1);
    else if (32'(win_len_r) > 32'(WINDOW_MAX)) win_c = CNT_W'(WINDOW_MAX);
    else                                     win_c = CNT_W'(win_len_r);
  end

  assign wp_nxt   = (wp_r == PTR_W'(WINDOW_MAX - 1)) ? '0 : wp_r + PTR_W'(1);
  assign fill_nxt = (fill_r == CNT_W'(WINDOW_MAX)) ? fill_r : fill_r + CNT_W'(1);
  assign n_nxt    = (fill_nxt < win_c) ? fill_nxt : win_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
      seen_r <= '0;
    end else if (cmd.load) begin
      if (in_last) begin
        wp_r   <= '0;
        fill_r <= '0;
        seen_r <= '0;
      end else if (st.match) begin
        wp_r   <= wp_nxt;
        fill_r <= fill_nxt;
        if (seen_r != '1) seen_r <= seen_r + IDX_W'(1);
      end
    end
  end

  // ring write and registered read
  assign rd_addr = (rd_ptr_r == '0) ? PTR_W'(WINDOW_MAX - 1) : rd_ptr_r - PTR_W'(1);

  always_ff @(posedge clk) begin
    if (sel_load) ring[wp_r] <= in_code;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_left_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_step;
      if (sel_load)          rd_left_r <= n_nxt;
      else if (cmd.rd_step)  rd_left_r <= rd_left_r - CNT_W'(1);
    end
  end

  // newest entry first, walking backwards through the ring
  always_ff @(posedge clk) begin
    if (sel_load) begin
      rd_ptr_r <= wp_nxt;
      n_r      <= n_nxt;
      idx_r    <= seen_r;
      sum_r    <= '0;
    end else begin
      if (cmd.rd_step) rd_ptr_r <= rd_addr;
      if (rd_vld_r)    sum_r    <= sum_r + SUM_W'(rd_data_r);
    end
  end

  // restoring divide of sum*256 by n; the top bits already sit below n
  assign shifted = {rem_r, quo_r[MEAN_W-1]};
  assign ge      = shifted >= {1'b0, n_r};
  assign diff    = shifted - {1'b0, n_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= sum_r[SUM_W-1:CODE_W];
      quo_r <= {sum_r[CODE_W-1:0], {FRAC_W{1'b0}}};
    end else if (cmd.div_step) begin
      rem_r <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo_r <= {quo_r[MEAN_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_start) begin
      div_cnt_r <= DIV_CNT_W'(MEAN_W);
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mean_r <= quo_r;
      oidx_r <= idx_r;
    end
  end

  assign st.match    = (in_chan == chan_sel_r);
  assign st.rd_empty = (rd_left_r == '0);
  assign st.acc_pend = rd_vld_r;
  assign st.div_last = (div_cnt_r == DIV_CNT_W'(1));

  assign mean_q8      = mean_r;
  assign sample_index = oidx_r;

endmodule

// File: hdl/channel_moving_average_top.sv
// top level of the channel moving average
//
//  channel | direction | tdata (low bit up)                     | side band
//  in_     | slave     | raw_code[11:0], zero pad to 16         | tuser source channel, tlast
//  out_    | master    | mean_q8[19:0], sample_index[35:20], pad| none
//  cfg_    | write     | cfg_wdata, register at cfg_index       | cfg_we
//
// an item on the selected channel gives its result after n ring reads, n being the samples
// averaged, the close of the sum, a 20-step restoring divider and the output load; the
// input reopens once that result is loaded, so the block takes no new item before it
// is through with the last; items on other channels give no result, input stays open
// rst_n is synchronous; it restores the register defaults and empties the history
// the output register holds one result; a stalled out_ stops the divider hand-off and input
module channel_moving_average_top #(
  parameter int WINDOW_MAX = chma_pkg::WINDOW_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [chma_pkg::IN_TDATA_W-1:0]    in_tdata,   // raw_code
  input  logic [chma_pkg::IN_TUSER_W-1:0]    in_tuser,   // source channel
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [chma_pkg::OUT_TDATA_W-1:0]   out_tdata,  // mean_q8, sample_index
  input  logic                               cfg_we,
  input  logic [chma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [chma_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import chma_pkg::*;

  cmd_t              cmd;
  stat_t             st;
  logic [MEAN_W-1:0] mean_q8;
  logic [IDX_W-1:0]  sample_index;

  chma_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  chma_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_code      (in_tdata[CODE_W-1:0]),
    .in_chan      (in_tuser[CHAN_W-1:0]),
    .in_last      (in_tlast),
    .cmd          (cmd),
    .st           (st),
    .mean_q8      (mean_q8),
    .sample_index (sample_index)
  );

  assign out_tdata = OUT_TDATA_W'({sample_index, mean_q8});

  // an item on another channel never holds up the next one
  a_skip_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !st.match) |=> in_tready)
    else $error("item on another channel stalled the input");

  // a selected item keeps the input closed while it is worked on
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && st.match) |=> !in_tready)
    else $error("input reopened before the mean was done");

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("output register overwritten");

  // the ring reads and the divider only run with the input closed
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.rd_step) |-> !in_tready)
    else $error("datapath busy while input open");

endmodule
